// File: hdl/assoc_block_cache_lru_assert.svh
// Assertion macros used by the checker file of the block cache.
`ifndef ASSOC_BLOCK_CACHE_LRU_ASSERT_SVH
`define ASSOC_BLOCK_CACHE_LRU_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define ACL_AST_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define ACL_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/acl_pkg.sv
// Types and constants of the associative block cache.
package acl_pkg;

    localparam int ENTRY_W = 6;
    localparam int CFG_W   = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_PUT    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  drum;
        logic [7:0]  block;
        logic [31:0] line_handle;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic [31:0]        line_handle_out;
        logic [ENTRY_W-1:0] entry;
        logic               evicted;
        logic [3:0]         evicted_drum;
        logic [7:0]         evicted_block;
    } t_out;

    // One cache line as stored in the memory.
    typedef struct packed {
        logic        valid;
        logic [3:0]  drum;
        logic [7:0]  block;
        logic [31:0] handle;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        logic clr;   // start of a new scan
        logic vld;   // read data holds an entry to compare
    } t_scan_ctl;

    typedef struct packed {
        logic found;
        logic free_found;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } t_state;

endpackage

// File: hdl/acl_mem.sv
// Line store: one write port, one read port, registered read data.
module acl_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  acl_pkg::t_entry          i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output acl_pkg::t_entry          o_rdata
);

    acl_pkg::t_entry mem [DEPTH];
    acl_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/acl_scan.sv
// Scan tracker: first tag match, first free line and oldest stamp.
module acl_scan #(
    parameter int IW = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acl_pkg::t_scan_ctl i_ctl,
    input  logic [IW-1:0]      i_idx,
    input  acl_pkg::t_entry    i_rd,
    input  logic [3:0]         i_key_drum,
    input  logic [7:0]         i_key_block,
    output acl_pkg::t_scan_flags o_flags,
    output logic [IW-1:0]      o_hit_idx,
    output logic [31:0]        o_hit_handle,
    output logic [IW-1:0]      o_free_idx,
    output logic [IW-1:0]      o_lru_idx,
    output logic [3:0]         o_lru_drum,
    output logic [7:0]         o_lru_block
);

    acl_pkg::t_scan_flags r_flags;
    acl_pkg::t_scan_flags n_flags;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_handle;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_lru_idx;
    logic [63:0]   r_lru_stamp;
    logic [3:0]    r_lru_drum;
    logic [7:0]    r_lru_block;
    logic          match;
    logic          older;

    assign match = i_rd.valid && (i_rd.drum == i_key_drum) && (i_rd.block == i_key_block);
    // first entry seeds the minimum; strict compare keeps the lower index on ties
    assign older = (i_idx == '0) || (i_rd.stamp < r_lru_stamp);

    always_comb begin
        n_flags = r_flags;
        if (match) begin
            n_flags.found = 1'b1;
        end
        if (!i_rd.valid) begin
            n_flags.free_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.clr) begin
            r_flags <= '0;
        end else if (i_ctl.vld) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (match && !r_flags.found) begin
                r_hit_idx    <= i_idx;
                r_hit_handle <= i_rd.handle;
            end
            if (!i_rd.valid && !r_flags.free_found) begin
                r_free_idx <= i_idx;
            end
            if (older) begin
                r_lru_idx   <= i_idx;
                r_lru_stamp <= i_rd.stamp;
                r_lru_drum  <= i_rd.drum;
                r_lru_block <= i_rd.block;
            end
        end
    end

    assign o_flags      = r_flags;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_handle = r_hit_handle;
    assign o_free_idx   = r_free_idx;
    assign o_lru_idx    = r_lru_idx;
    assign o_lru_drum   = r_lru_drum;
    assign o_lru_block  = r_lru_block;

endmodule

// File: hdl/assoc_block_cache_lru.sv
// Top level of the fully associative block cache with LRU replacement.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------
//  config    i_cfg_we               i_cfg_data (7 bits)
//  command   start & !busy          i_in  (acl_pkg::t_in)
//  result    o_done, one cycle      o_out (acl_pkg::t_out)
//
// An access runs from accept until busy falls: one memory read per line in
// the scan over the n active lines (64 at the default), a compare of the
// last line, then one write-back.
// The result beat shows in the cycle after write-back; busy is low then.
// After reset a clearing pass over all MAX_LINES lines runs with busy high.
// Results cannot be stalled; config writes are taken at any time.
module assoc_block_cache_lru #(
    parameter int MAX_LINES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [acl_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  acl_pkg::t_in               i_in,
    output logic                       o_done,
    output acl_pkg::t_out              o_out
);

    localparam int IW = $clog2(MAX_LINES);
    localparam logic [IW-1:0] LAST_LINE = IW'(MAX_LINES - 1);

    acl_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_addr;
    logic [IW-1:0]   r_last;
    logic            r_cmp_vld;
    logic [IW-1:0]   r_cmp_idx;
    acl_pkg::t_in    r_req;
    logic [63:0]     r_stamp;
    logic [63:0]     r_stamp_ctr;
    logic [acl_pkg::CFG_W-1:0] r_cfg;
    logic            r_done;
    acl_pkg::t_out   r_out;

    logic            rd_en;
    logic            wr_en;
    logic [IW-1:0]   waddr;
    acl_pkg::t_entry wdata;
    acl_pkg::t_entry rdata;
    acl_pkg::t_scan_ctl scan_ctl;
    acl_pkg::t_out   dec_out;
    logic            accept;
    logic [31:0]     act;
    logic [31:0]     act_m1;
    logic [31:0]     wide_idx;

    acl_pkg::t_scan_flags flags;
    logic [IW-1:0]   hit_idx;
    logic [31:0]     hit_handle;
    logic [IW-1:0]   free_idx;
    logic [IW-1:0]   lru_idx;
    logic [3:0]      lru_drum;
    logic [7:0]      lru_block;

    assign busy   = (r_state != acl_pkg::ST_IDLE);
    assign accept = start && !busy;

    // active count clamped to 1..MAX_LINES
    always_comb begin
        if (r_cfg == '0) begin
            act = 32'd1;
        end else if (32'(r_cfg) > 32'(MAX_LINES)) begin
            act = 32'(MAX_LINES);
        end else begin
            act = 32'(r_cfg);
        end
        act_m1 = act - 32'd1;
    end

    acl_mem #(
        .DEPTH(MAX_LINES)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (rd_en),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    acl_scan #(
        .IW(IW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_cmp_idx),
        .i_rd        (rdata),
        .i_key_drum  (r_req.drum),
        .i_key_block (r_req.block),
        .o_flags     (flags),
        .o_hit_idx   (hit_idx),
        .o_hit_handle(hit_handle),
        .o_free_idx  (free_idx),
        .o_lru_idx   (lru_idx),
        .o_lru_drum  (lru_drum),
        .o_lru_block (lru_block)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            acl_pkg::ST_CLEAR: begin
                if (r_addr == LAST_LINE) n_state = acl_pkg::ST_IDLE;
            end
            acl_pkg::ST_IDLE: begin
                if (start) n_state = acl_pkg::ST_SCAN;
            end
            acl_pkg::ST_SCAN: begin
                if (r_addr == r_last) n_state = acl_pkg::ST_LAST;
            end
            acl_pkg::ST_LAST: begin
                n_state = acl_pkg::ST_WRITE;
            end
            acl_pkg::ST_WRITE: begin
                n_state = acl_pkg::ST_IDLE;
            end
            default: begin
                n_state = acl_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the state machine and write-back decision
    always_comb begin
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        waddr        = r_addr;
        wdata        = '0;
        scan_ctl.clr = 1'b0;
        scan_ctl.vld = r_cmp_vld;
        dec_out      = '0;
        wide_idx     = '0;
        case (r_state)
            acl_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
            end
            acl_pkg::ST_IDLE: begin
                scan_ctl.clr = accept;
            end
            acl_pkg::ST_SCAN: begin
                rd_en = 1'b1;
            end
            acl_pkg::ST_WRITE: begin
                wdata.valid  = 1'b1;
                wdata.drum   = r_req.drum;
                wdata.block  = r_req.block;
                wdata.handle = r_req.line_handle;
                wdata.stamp  = r_stamp;
                if (flags.found) begin
                    wr_en       = 1'b1;
                    waddr       = hit_idx;
                    dec_out.hit = 1'b1;
                    if (r_req.operation == acl_pkg::OP_LOOKUP) begin
                        wdata.handle            = hit_handle;
                        dec_out.line_handle_out = hit_handle;
                    end
                end else if (r_req.operation == acl_pkg::OP_PUT) begin
                    wr_en = 1'b1;
                    if (flags.free_found) begin
                        waddr = free_idx;
                    end else begin
                        waddr                 = lru_idx;
                        dec_out.evicted       = 1'b1;
                        dec_out.evicted_drum  = lru_drum;
                        dec_out.evicted_block = lru_block;
                    end
                end
                if (wr_en) begin
                    wide_idx      = 32'(waddr);
                    dec_out.entry = wide_idx[acl_pkg::ENTRY_W-1:0];
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acl_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            r_stamp_ctr <= '0;
            r_cfg       <= acl_pkg::CFG_RESET;
            r_done      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            r_done    <= (r_state == acl_pkg::ST_WRITE);
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (accept) begin
                r_addr      <= '0;
                r_stamp_ctr <= r_stamp_ctr + 64'd1;
            end else if ((r_state == acl_pkg::ST_CLEAR) || (r_state == acl_pkg::ST_SCAN)) begin
                r_addr <= r_addr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (accept) begin
            r_req   <= i_in;
            r_stamp <= r_stamp_ctr;
            r_last  <= act_m1[IW-1:0];
        end
        if (r_state == acl_pkg::ST_WRITE) begin
            r_out <= dec_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// File: hdl/acl_checker.sv
// Port-level checker for the block cache, bound to the top level.
`include "assoc_block_cache_lru_assert.svh"

module acl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input acl_pkg::t_out o_out
);

    `ACL_AST_NXT(a_accept_busy, start && !busy, busy)
    `ACL_AST_NXT(a_no_quick_done, start && !busy, !o_done)
    `ACL_AST_IMP(a_done_idle, o_done, !busy)
    `ACL_AST_IMP(a_miss_zero, o_done && !o_out.hit, o_out.line_handle_out == 32'd0)
    `ACL_AST_IMP(a_evict_miss, o_done && o_out.evicted, !o_out.hit)

endmodule

bind assoc_block_cache_lru acl_checker u_acl_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_done (o_done),
    .o_out  (o_out)
);

// File: verif/tb_top.sv
// Self-checking testbench for the associative block cache with LRU replacement.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_LINES   = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 4;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_cfg_we   = 1'b0;
    logic [acl_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic         start      = 1'b0;
    logic         busy;
    acl_pkg::t_in i_in       = '0;
    logic         o_done;
    acl_pkg::t_out o_out;

    // shadow of the cache contents
    bit           line_valid [MAX_LINES];
    logic [3:0]   line_drum  [MAX_LINES];
    logic [7:0]   line_block [MAX_LINES];
    logic [31:0]  line_data  [MAX_LINES];
    logic [63:0]  line_stamp [MAX_LINES];
    logic [63:0]  next_stamp = '0;
    logic [acl_pkg::CFG_W-1:0] lines_cfg = acl_pkg::CFG_RESET;

    acl_pkg::t_out access_results_due[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           burst_left     = 0;

    assoc_block_cache_lru #(.MAX_LINES(MAX_LINES)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    // Cache access as seen by the shadow; updates shadow state, returns the beat.
    function automatic acl_pkg::t_out predict_access(acl_pkg::t_in cmd);
        acl_pkg::t_out res;
        int         active;
        int         sel;
        bit         found;
        bit         free_found;
        logic [63:0] stamp;
        res        = '0;
        sel        = 0;
        found      = 1'b0;
        free_found = 1'b0;
        active = (lines_cfg == 0) ? 1 : ((lines_cfg > MAX_LINES) ? MAX_LINES : int'(lines_cfg));
        stamp      = next_stamp;
        next_stamp = next_stamp + 64'd1;

        for (int i = 0; i < active && !found; i++) begin
            if (line_valid[i] && line_drum[i] == cmd.drum && line_block[i] == cmd.block) begin
                sel   = i;
                found = 1'b1;
            end
        end

        if (cmd.operation == acl_pkg::OP_LOOKUP) begin
            if (found) begin
                line_stamp[sel]     = stamp;
                res.hit             = 1'b1;
                res.line_handle_out = line_data[sel];
                res.entry           = sel[acl_pkg::ENTRY_W-1:0];
            end
            return res;
        end

        if (found) begin
            line_data[sel]  = cmd.line_handle;
            line_stamp[sel] = stamp;
            res.hit         = 1'b1;
            res.entry       = sel[acl_pkg::ENTRY_W-1:0];
            return res;
        end

        for (int i = 0; i < active && !free_found; i++) begin
            if (!line_valid[i]) begin
                sel        = i;
                free_found = 1'b1;
            end
        end
        if (!free_found) begin
            // oldest stamp wins, strict compare keeps the lower index on ties
            sel = 0;
            for (int i = 1; i < active; i++)
                if (line_stamp[i] < line_stamp[sel]) sel = i;
            res.evicted       = 1'b1;
            res.evicted_drum  = line_drum[sel];
            res.evicted_block = line_block[sel];
        end

        line_valid[sel] = 1'b1;
        line_drum[sel]  = cmd.drum;
        line_block[sel] = cmd.block;
        line_data[sel]  = cmd.line_handle;
        line_stamp[sel] = stamp;
        res.entry       = sel[acl_pkg::ENTRY_W-1:0];
        return res;
    endfunction

    // Result checker: every beat against the oldest prediction.
    always @(posedge i_clk) begin
        acl_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (access_results_due.size() == 0) begin
                flag_error("result beat with no access pending");
            end else begin
                want = access_results_due.pop_front();
                check_field("hit", want.hit, o_out.hit);
                check_field("line_handle_out", want.line_handle_out, o_out.line_handle_out);
                check_field("entry", want.entry, o_out.entry);
                check_field("evicted", want.evicted, o_out.evicted);
                check_field("evicted_drum", want.evicted_drum, o_out.evicted_drum);
                check_field("evicted_block", want.evicted_block, o_out.evicted_block);
            end
        end
    end

    function automatic acl_pkg::t_in random_cmd();
        acl_pkg::t_in c;
        c.operation   = 1'($urandom_range(0, 1));
        c.drum        = 4'($urandom_range(0, 15));
        c.block       = 8'($urandom_range(0, 255));
        c.line_handle = $urandom;
        return c;
    endfunction

    // Returns at the edge that took the beat; start is left high.
    task automatic send_cmd(input acl_pkg::t_in cmd);
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        access_results_due.push_back(predict_access(cmd));
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        i_in  <= random_cmd();
        repeat (cycles) @(posedge i_clk);
    endtask

    // bursts of back-to-back commands with random gaps in between
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_gap($urandom_range(1, 80));
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic issue(input logic op, input logic [3:0] d, input logic [7:0] b,
                         input logic [31:0] h);
        acl_pkg::t_in c;
        c.operation   = op;
        c.drum        = d;
        c.block       = b;
        c.line_handle = h;
        send_cmd(c);
        pace();
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (access_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // block must be idle here
    task automatic write_line_count(input logic [acl_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lines_cfg   = value;
    endtask

    task automatic test_basic_ops();
        issue(acl_pkg::OP_LOOKUP, 4'd0,  8'd0,   32'h0);
        issue(acl_pkg::OP_PUT,    4'd0,  8'd0,   32'h0);           // zero handle is stored
        issue(acl_pkg::OP_LOOKUP, 4'd0,  8'd0,   32'hFFFF_FFFF);
        issue(acl_pkg::OP_PUT,    4'd15, 8'd255, 32'hFFFF_FFFF);
        issue(acl_pkg::OP_LOOKUP, 4'd15, 8'd255, 32'h0);
        issue(acl_pkg::OP_PUT,    4'd15, 8'd255, 32'h5A5A_A5A5);   // update in place
        issue(acl_pkg::OP_LOOKUP, 4'd15, 8'd255, 32'h0);
        issue(acl_pkg::OP_LOOKUP, 4'd15, 8'd0,   32'h0);
    endtask

    task automatic test_lru_replacement();
        drain_pipeline();
        write_line_count(7'd3);
        issue(acl_pkg::OP_PUT,    4'd1, 8'd1, 32'h1111_0001);
        issue(acl_pkg::OP_LOOKUP, 4'd0, 8'd0, 32'h0);
        issue(acl_pkg::OP_PUT,    4'd2, 8'd2, 32'h2222_0002);      // full, evicts oldest
        issue(acl_pkg::OP_PUT,    4'd3, 8'd3, 32'h3333_0003);
    endtask

    task automatic test_line_count_limits();
        drain_pipeline();
        write_line_count(7'd0);                          // behaves as one line
        issue(acl_pkg::OP_PUT,    4'd4, 8'd4, 32'h4444_0004);
        issue(acl_pkg::OP_LOOKUP, 4'd2, 8'd2, 32'h0);     // sits above the active range
        drain_pipeline();
        write_line_count(7'd127);                        // clamps to the built depth
        issue(acl_pkg::OP_LOOKUP, 4'd2, 8'd2, 32'h0);
        issue(acl_pkg::OP_LOOKUP, 4'd4, 8'd4, 32'h0);
        drain_pipeline();
        write_line_count(7'd1);
        issue(acl_pkg::OP_PUT,    4'd7, 8'd7, 32'h7777_0007);
        drain_pipeline();
        write_line_count(7'd64);
        issue(acl_pkg::OP_PUT,    4'd8, 8'd8, 32'h8888_0008);
        issue(acl_pkg::OP_LOOKUP, 4'd3, 8'd3, 32'h0);
    endtask

    task automatic test_random_traffic(input logic [acl_pkg::CFG_W-1:0] count,
                                       input int n_items);
        logic [11:0]  tag_pool [128];
        int           active;
        int           pool_len;
        int           roll;
        acl_pkg::t_in c;
        drain_pipeline();
        write_line_count(count);
        active   = (count == 0) ? 1 : ((count > MAX_LINES) ? MAX_LINES : int'(count));
        // a pool a bit larger than the cache keeps hits and evictions both common
        pool_len = active + 1 + $urandom_range(0, active / 2 + 2);
        for (int i = 0; i < pool_len; i++) tag_pool[i] = 12'($urandom);
        for (int n = 0; n < n_items; n++) begin
            c    = random_cmd();
            roll = $urandom_range(0, 99);
            if (roll < 90) {c.drum, c.block} = tag_pool[$urandom_range(0, pool_len - 1)];
            roll = $urandom_range(0, 99);
            if (roll < 4)      c.line_handle = 32'h0;
            else if (roll < 8) c.line_handle = 32'hFFFF_FFFF;
            send_cmd(c);
            pace();
        end
    endtask

    initial begin
        foreach (line_valid[i]) line_valid[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_lru_replacement();
        test_line_count_limits();
        test_random_traffic(7'd64, 70);
        test_random_traffic(7'd1, 70);
        test_random_traffic(7'd2, 70);
        test_random_traffic(7'd8, 70);
        test_random_traffic(7'd0, 60);
        test_random_traffic(7'd127, 70);
        test_random_traffic(7'd65, 60);
        test_random_traffic(7'd20, 80);
        test_random_traffic(7'($urandom_range(1, 64)), 80);
        test_random_traffic(7'd64, 70);
        drain_pipeline();

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/acl_pkg.sv
hdl/acl_mem.sv
hdl/acl_scan.sv
hdl/assoc_block_cache_lru.sv
hdl/acl_checker.sv
verif/tb_top.sv
